// ===== rtl/core/rsq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsq_pkg
// Shared constants for the rotated sprite quad corner generator.
// ----------------------------------------------------------------------------
package rsq_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int ANGLE_WIDTH_DEF = 16;
    localparam int TRIG_W          = 18;
    localparam int QUEUE_DEPTH     = 2;
    localparam int POLY_W          = 32;
    localparam int POLY_PROD_W     = 63;

    localparam logic [POLY_W-1:0] C1 = 32'd1686629713;
    localparam logic [POLY_W-1:0] C3 = 32'd693598670;
    localparam logic [POLY_W-1:0] C5 = 32'd85569300;
    localparam logic [POLY_W-1:0] C7 = 32'd5027050;
    localparam logic [POLY_W-1:0] C9 = 32'd172280;

    localparam logic [1:0] CORNER_FIRST = 2'd0;
    localparam logic [1:0] CORNER_LAST  = 2'd3;

    // coefficient subtracted at each Horner stage of the sine polynomial
    function automatic logic [POLY_W-1:0] poly_coef(input int stage);
        logic [POLY_W-1:0] c;
        case (stage)
            4:       c = C7;
            5:       c = C5;
            6:       c = C3;
            default: c = C1;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/rsq_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsq_queue
// Small register FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module rsq_queue
    import rsq_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_stall,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_pop,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push;
    logic             pop;

    assign wr_stall = (cnt_reg == CNT_W'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_pop && rd_valid;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/core/rsq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsq_front
// Accepts sprite items, evaluates sine/cosine and the pivot offsets in an
// eight-stage pipeline.
// ----------------------------------------------------------------------------
module rsq_front
    import rsq_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] pos_x,
    input  logic signed [COORD_WIDTH-1:0] pos_y,
    input  logic signed [COORD_WIDTH-1:0] pos_z,
    input  logic signed [COORD_WIDTH-1:0] pivot_x,
    input  logic signed [COORD_WIDTH-1:0] pivot_y,
    input  logic [COORD_WIDTH-2:0]        width,
    input  logic [COORD_WIDTH-2:0]        height,
    input  logic [ANGLE_WIDTH-1:0]        angle,
    input  logic                          mirror_u,
    input  logic                          mirror_v,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [COORD_WIDTH-1:0]        out_pos_x,
    output logic [COORD_WIDTH-1:0]        out_pos_y,
    output logic [COORD_WIDTH-1:0]        out_pos_z,
    output logic [COORD_WIDTH-2:0]        out_width,
    output logic [COORD_WIDTH-2:0]        out_height,
    output logic                          out_mirror_u,
    output logic                          out_mirror_v,
    output logic [COORD_WIDTH-1:0]        out_ox0,
    output logic [COORD_WIDTH-1:0]        out_oy0,
    output logic [TRIG_W-1:0]             out_sin,
    output logic [TRIG_W-1:0]             out_cos
);

    localparam int CW = COORD_WIDTH;
    localparam int QB = ANGLE_WIDTH - 2;
    localparam int SH = 30 - QB;
    localparam int NS = 8;
    localparam int PW = 5 * CW;
    localparam logic [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
    localparam logic [ANGLE_WIDTH-1:0] QTR = {2'b01, {QB{1'b0}}};

    logic [NS:1]          v_reg;
    logic                 en;
    logic [PW-1:0]        pay_reg [1:NS];
    logic [ANGLE_WIDTH-1:0] ang_reg;
    logic [CW-1:0]        pvx_reg;
    logic [CW-1:0]        pvy_reg;
    logic [2*CW-1:0]      offp_reg [0:1];
    logic                 offn_reg [0:1];
    logic [CW-1:0]        off_reg [0:1][3:NS];
    logic [TRIG_W-1:0]    trig_reg [0:1];

    assign en        = !v_reg[NS] || !out_stall;
    assign in_stall  = !en;
    assign out_valid = v_reg[NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NS-1:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pay_reg[1] <= {pos_x, pos_y, pos_z, width, height, mirror_u, mirror_v};
            ang_reg    <= angle;
            pvx_reg    <= pivot_x;
            pvy_reg    <= pivot_y;
            for (int i = 2; i <= NS; i++)
            begin
                pay_reg[i] <= pay_reg[i-1];
            end
        end
    end

    // pivot offsets: -(pivot * size), rounded and saturated
    for (genvar o = 0; o < 2; o++)
    begin : g_off
        logic [CW-1:0] pv;
        logic [CW-2:0] sz;
        logic [CW-1:0] mag;
        logic [2*CW:0] rnd;
        logic [CW-1:0] mc;

        assign pv  = (o == 0) ? pvx_reg : pvy_reg;
        assign sz  = (o == 0) ? pay_reg[1][2*CW-1:CW+1] : pay_reg[1][CW:2];
        assign mag = pv[CW-1] ? (~pv + 1'b1) : pv;
        assign rnd = {1'b0, offp_reg[o]} + (2*CW+1)'(32'h8000);
        assign mc  = (rnd[2*CW:16] > {{(CW-15){1'b0}}, MAXV}) ? MAXV : rnd[CW+15:16];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                offp_reg[o]   <= (2*CW)'(mag) * (2*CW)'(sz);
                offn_reg[o]   <= pv[CW-1];
                off_reg[o][3] <= offn_reg[o] ? mc : (~mc + 1'b1);
                for (int i = 4; i <= NS; i++)
                begin
                    off_reg[o][i] <= off_reg[o][i-1];
                end
            end
        end
    end

    // sine lane and cosine lane (angle plus a quarter turn)
    for (genvar j = 0; j < 2; j++)
    begin : g_trig
        logic [ANGLE_WIDTH-1:0] a;
        logic [QB:0]            r;
        logic [30:0]            tv;
        logic [30:0]            t_reg [2:6];
        logic [30:0]            t2_reg [3:5];
        logic [POLY_PROD_W-1:0] raw_reg [2:7];
        logic                   neg_reg [2:7];
        logic [32:0]            sr;
        logic [18:0]            vr;
        logic [16:0]            vc;
        logic [POLY_W-1:0]      p7;

        assign a  = (j == 0) ? ang_reg : ang_reg + QTR;
        assign r  = a[ANGLE_WIDTH-2] ? ({1'b1, {QB{1'b0}}} - {1'b0, a[QB-1:0]})
                                     : {1'b0, a[QB-1:0]};
        assign tv = {r, {SH{1'b0}}};
        assign p7 = C1 - raw_reg[6][61:30];
        assign sr = {1'b0, raw_reg[7][61:30]} + 33'h2000;
        assign vr = sr[32:14];
        assign vc = (vr > 19'd65536) ? 17'h10000 : vr[16:0];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                t_reg[2]   <= tv;
                raw_reg[2] <= POLY_PROD_W'(tv) * POLY_PROD_W'(tv);
                neg_reg[2] <= a[ANGLE_WIDTH-1];
                t2_reg[3]  <= raw_reg[2][60:30];
                raw_reg[3] <= POLY_PROD_W'(C9) * POLY_PROD_W'(raw_reg[2][60:30]);
                for (int k = 4; k <= 6; k++)
                begin
                    raw_reg[k] <= POLY_PROD_W'(poly_coef(k) - raw_reg[k-1][61:30])
                                  * POLY_PROD_W'(t2_reg[k-1]);
                end
                for (int k = 4; k <= 5; k++)
                begin
                    t2_reg[k] <= t2_reg[k-1];
                end
                raw_reg[7] <= POLY_PROD_W'(p7) * POLY_PROD_W'(t_reg[6]);
                for (int k = 3; k <= 6; k++)
                begin
                    t_reg[k] <= t_reg[k-1];
                end
                for (int k = 3; k <= 7; k++)
                begin
                    neg_reg[k] <= neg_reg[k-1];
                end
                trig_reg[j] <= neg_reg[7] ? (~{1'b0, vc} + 1'b1) : {1'b0, vc};
            end
        end
    end

    assign out_pos_x    = pay_reg[NS][5*CW-1:4*CW];
    assign out_pos_y    = pay_reg[NS][4*CW-1:3*CW];
    assign out_pos_z    = pay_reg[NS][3*CW-1:2*CW];
    assign out_width    = pay_reg[NS][2*CW-1:CW+1];
    assign out_height   = pay_reg[NS][CW:2];
    assign out_mirror_u = pay_reg[NS][1];
    assign out_mirror_v = pay_reg[NS][0];
    assign out_ox0      = off_reg[0][NS];
    assign out_oy0      = off_reg[1][NS];
    assign out_sin      = trig_reg[0];
    assign out_cos      = trig_reg[1];

endmodule

// ===== rtl/core/rsq_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsq_back
// Emits each item's four corners, one per unstalled cycle: offset, rotate,
// translate, with rounding and saturation.
// ----------------------------------------------------------------------------
module rsq_back
    import rsq_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_pop,
    input  logic [COORD_WIDTH-1:0]        in_pos_x,
    input  logic [COORD_WIDTH-1:0]        in_pos_y,
    input  logic [COORD_WIDTH-1:0]        in_pos_z,
    input  logic [COORD_WIDTH-2:0]        in_width,
    input  logic [COORD_WIDTH-2:0]        in_height,
    input  logic                          in_mirror_u,
    input  logic                          in_mirror_v,
    input  logic [COORD_WIDTH-1:0]        in_ox0,
    input  logic [COORD_WIDTH-1:0]        in_oy0,
    input  logic [TRIG_W-1:0]             in_sin,
    input  logic [TRIG_W-1:0]             in_cos,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COORD_WIDTH-1:0] vert_x,
    output logic signed [COORD_WIDTH-1:0] vert_y,
    output logic signed [COORD_WIDTH-1:0] vert_z,
    output logic                          tex_u,
    output logic                          tex_v,
    output logic [1:0]                    corner_index,
    output logic                          last_vertex
);

    localparam int CW = COORD_WIDTH;
    localparam int MW = CW + 17;
    localparam int SW = 3 * CW + 5;
    localparam logic [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

    function automatic logic [CW-1:0] sat1(input logic [CW:0] v);
        logic [CW-1:0] res;
        if (v[CW] != v[CW-1])
        begin
            res = v[CW] ? MINV : MAXV;
        end
        else
        begin
            res = v[CW-1:0];
        end
        return res;
    endfunction

    logic                en;
    logic [4:1]          v_reg;
    logic                vout_reg;
    logic [1:0]          k_reg;
    logic [CW-1:0]       ox_reg, oy_reg;
    logic [TRIG_W-1:0]   c_reg, s_reg;
    logic [SW-1:0]       side_reg [1:4];
    logic [MW-1:0]       pm_reg [0:3];
    logic                pn_reg [0:3];
    logic [CW-1:0]       mr_reg [0:3];
    logic [CW-1:0]       rx_reg, ry_reg;
    logic [CW-1:0]       ox_next, oy_next;
    logic [CW-1:0]       op_x [0:3];
    logic [TRIG_W-1:0]   op_t [0:3];

    assign en        = !vout_reg || !out_stall;
    assign in_pop    = en && in_valid && (k_reg == CORNER_LAST);
    assign out_valid = vout_reg;

    assign ox_next = k_reg[0] ? sat1({in_ox0[CW-1], in_ox0} + {2'b00, in_width})  : in_ox0;
    assign oy_next = k_reg[1] ? sat1({in_oy0[CW-1], in_oy0} + {2'b00, in_height}) : in_oy0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= '0;
            vout_reg <= 1'b0;
            k_reg    <= CORNER_FIRST;
        end
        else if (en)
        begin
            v_reg    <= {v_reg[3:1], in_valid};
            vout_reg <= v_reg[4];
            if (in_valid)
            begin
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ox_reg      <= ox_next;
            oy_reg      <= oy_next;
            c_reg       <= in_cos;
            s_reg       <= in_sin;
            side_reg[1] <= {in_pos_x, in_pos_y, in_pos_z, k_reg[0] ^ in_mirror_u,
                            k_reg[1] ^ in_mirror_v, k_reg, k_reg == CORNER_LAST};
            for (int i = 2; i <= 4; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // x' = c*ox + s*oy,  y' = c*oy - s*ox
    assign op_t[0] = c_reg;  assign op_x[0] = ox_reg;
    assign op_t[1] = s_reg;  assign op_x[1] = oy_reg;
    assign op_t[2] = c_reg;  assign op_x[2] = oy_reg;
    assign op_t[3] = s_reg;  assign op_x[3] = ox_reg;

    for (genvar p = 0; p < 4; p++)
    begin : g_mul
        logic [TRIG_W-1:0] tm;
        logic [CW-1:0]     xm;
        logic [MW:0]       rnd;
        logic [CW+1:0]     m;
        logic [CW+1:0]     lim;
        logic [CW-1:0]     mc;

        assign tm  = op_t[p][TRIG_W-1] ? (~op_t[p] + 1'b1) : op_t[p];
        assign xm  = op_x[p][CW-1] ? (~op_x[p] + 1'b1) : op_x[p];
        assign rnd = {1'b0, pm_reg[p]} + (MW+1)'(32'h8000);
        assign m   = rnd[MW:16];
        assign lim = pn_reg[p] ? {2'b00, MINV} : {2'b00, MAXV};
        assign mc  = (m > lim) ? lim[CW-1:0] : m[CW-1:0];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pm_reg[p] <= MW'(tm[16:0]) * MW'(xm);
                pn_reg[p] <= op_t[p][TRIG_W-1] ^ op_x[p][CW-1];
                mr_reg[p] <= pn_reg[p] ? (~mc + 1'b1) : mc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg <= sat1({mr_reg[0][CW-1], mr_reg[0]} + {mr_reg[1][CW-1], mr_reg[1]});
            ry_reg <= sat1({mr_reg[2][CW-1], mr_reg[2]} - {mr_reg[3][CW-1], mr_reg[3]});
            vert_x <= sat1({side_reg[4][SW-1], side_reg[4][SW-1 -: CW]}
                           + {rx_reg[CW-1], rx_reg});
            vert_y <= sat1({side_reg[4][SW-1-CW], side_reg[4][SW-1-CW -: CW]}
                           + {ry_reg[CW-1], ry_reg});
            vert_z       <= side_reg[4][SW-1-2*CW -: CW];
            tex_u        <= side_reg[4][4];
            tex_v        <= side_reg[4][3];
            corner_index <= side_reg[4][2:1];
            last_vertex  <= side_reg[4][0];
        end
    end

endmodule

// ===== rtl/core/rotated_sprite_quad_corners.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_sprite_quad_corners
// Turns one sprite item into the four corner vertices of a rotated quad.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid/in_stall    pos_x pos_y pos_z pivot_x pivot_y width
//                                height angle mirror_u mirror_v
//  out      out_valid/out_stall  vert_x vert_y vert_z tex_u tex_v
//                                corner_index last_vertex
//
//  The corner stage emits one vertex per cycle while out_stall is low; the
//  front takes an item every cycle while the two-entry queue has room, so
//  new items are accepted while earlier corners are still being emitted.
//  Reset clears valids, queue pointers and the corner count.
//  out_stall freezes the corner stage only; the front keeps going until
//  the queue fills.
// ----------------------------------------------------------------------------
module rotated_sprite_quad_corners
    import rsq_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] pos_x,
    input  logic signed [COORD_WIDTH-1:0] pos_y,
    input  logic signed [COORD_WIDTH-1:0] pos_z,
    input  logic signed [COORD_WIDTH-1:0] pivot_x,
    input  logic signed [COORD_WIDTH-1:0] pivot_y,
    input  logic [COORD_WIDTH-2:0]        width,
    input  logic [COORD_WIDTH-2:0]        height,
    input  logic [ANGLE_WIDTH-1:0]        angle,
    input  logic                          mirror_u,
    input  logic                          mirror_v,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COORD_WIDTH-1:0] vert_x,
    output logic signed [COORD_WIDTH-1:0] vert_y,
    output logic signed [COORD_WIDTH-1:0] vert_z,
    output logic                          tex_u,
    output logic                          tex_v,
    output logic [1:0]                    corner_index,
    output logic                          last_vertex
);

    localparam int CW = COORD_WIDTH;
    localparam int QW = 7 * CW + 2 * TRIG_W;

    logic              f_valid, f_stall;
    logic [CW-1:0]     f_px, f_py, f_pz, f_ox0, f_oy0;
    logic [CW-2:0]     f_w, f_h;
    logic              f_mu, f_mv;
    logic [TRIG_W-1:0] f_sin, f_cos;
    logic              q_valid, q_pop;
    logic [QW-1:0]     q_wdata, q_rdata;

    rsq_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .pivot_x      (pivot_x),
        .pivot_y      (pivot_y),
        .width        (width),
        .height       (height),
        .angle        (angle),
        .mirror_u     (mirror_u),
        .mirror_v     (mirror_v),
        .out_valid    (f_valid),
        .out_stall    (f_stall),
        .out_pos_x    (f_px),
        .out_pos_y    (f_py),
        .out_pos_z    (f_pz),
        .out_width    (f_w),
        .out_height   (f_h),
        .out_mirror_u (f_mu),
        .out_mirror_v (f_mv),
        .out_ox0      (f_ox0),
        .out_oy0      (f_oy0),
        .out_sin      (f_sin),
        .out_cos      (f_cos)
    );

    assign q_wdata = {f_px, f_py, f_pz, f_w, f_h, f_mu, f_mv, f_ox0, f_oy0, f_sin, f_cos};

    rsq_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_stall (f_stall),
        .wr_data  (q_wdata),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_data  (q_rdata)
    );

    rsq_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (q_valid),
        .in_pop       (q_pop),
        .in_pos_x     (q_rdata[QW-1 -: CW]),
        .in_pos_y     (q_rdata[QW-1-CW -: CW]),
        .in_pos_z     (q_rdata[QW-1-2*CW -: CW]),
        .in_width     (q_rdata[QW-1-3*CW -: CW-1]),
        .in_height    (q_rdata[QW-4*CW -: CW-1]),
        .in_mirror_u  (q_rdata[2*CW+2*TRIG_W+1]),
        .in_mirror_v  (q_rdata[2*CW+2*TRIG_W]),
        .in_ox0       (q_rdata[2*CW+2*TRIG_W-1 -: CW]),
        .in_oy0       (q_rdata[CW+2*TRIG_W-1 -: CW]),
        .in_sin       (q_rdata[2*TRIG_W-1 -: TRIG_W]),
        .in_cos       (q_rdata[TRIG_W-1:0]),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .vert_x       (vert_x),
        .vert_y       (vert_y),
        .vert_z       (vert_z),
        .tex_u        (tex_u),
        .tex_v        (tex_v),
        .corner_index (corner_index),
        .last_vertex  (last_vertex)
    );

endmodule

// ===== dv/tb_rotated_sprite_quad_corners.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rotated_sprite_quad_corners
// Self-checking bench: feeds sprite items, predicts the four rotated quad
// corners of each in Q16.16 fixed point, and compares every vertex item.
// ----------------------------------------------------------------------------
module tb_rotated_sprite_quad_corners;
    import rsq_pkg::*;

    localparam int CW = COORD_WIDTH_DEF;
    localparam int AW = ANGLE_WIDTH_DEF;
    localparam int QB = AW - 2;

    typedef struct packed {
        logic signed [CW-1:0] px, py, pz, pvx, pvy;
        logic [CW-2:0]        w, h;
        logic [AW-1:0]        ang;
        logic                 mu, mv;
    } sprite_t;

    typedef struct packed {
        logic signed [CW-1:0] x, y, z;
        logic                 u, v;
        logic [1:0]           idx;
        logic                 last;
    } vertex_t;

    typedef struct {
        sprite_t s;
        logic    known;
        logic signed [CW-1:0] x0, y0;
    } row_t;

    logic clk, rst_n;
    logic in_valid, in_stall, out_valid, out_stall;
    sprite_t cur;
    logic signed [CW-1:0] vert_x, vert_y, vert_z;
    logic tex_u, tex_v, last_vertex;
    logic [1:0] corner_index;

    vertex_t corners_due[$];
    row_t    rows[$];
    int      errors = 0;
    bit      calm = 0;
    bit      feeding_done = 0;

    rotated_sprite_quad_corners dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .pos_x(cur.px), .pos_y(cur.py), .pos_z(cur.pz),
        .pivot_x(cur.pvx), .pivot_y(cur.pvy),
        .width(cur.w), .height(cur.h), .angle(cur.ang),
        .mirror_u(cur.mu), .mirror_v(cur.mv),
        .out_valid(out_valid), .out_stall(out_stall),
        .vert_x(vert_x), .vert_y(vert_y), .vert_z(vert_z),
        .tex_u(tex_u), .tex_v(tex_v),
        .corner_index(corner_index), .last_vertex(last_vertex)
    );

    initial begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial begin
        #50ms;
        $display("rotated_sprite_quad_corners regression: fail");
        $finish;
    end

    function automatic longint clampc(longint v);
        longint hi, lo;
        hi = (longint'(1) <<< (CW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        bit neg;
        logic [127:0] p, lim;
        neg = (a < 0) != (b < 0);
        p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
        p = (p + 128'h8000) >> 16;
        lim = (128'd1 << (CW - 1)) - (neg ? 0 : 1);
        if (p > lim) p = lim;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint turn_sine(logic [AW-1:0] a);
        logic [1:0] quad;
        logic [63:0] r, t, t2, pl, sv, v;
        quad = a[AW-1:AW-2];
        r = 64'(a[QB-1:0]);
        if (quad[0]) r = (64'd1 << QB) - r;
        t = r << (30 - QB);
        t2 = (t * t) >> 30;
        pl = 64'(C9);
        pl = 64'(C7) - ((pl * t2) >> 30);
        pl = 64'(C5) - ((pl * t2) >> 30);
        pl = 64'(C3) - ((pl * t2) >> 30);
        pl = 64'(C1) - ((pl * t2) >> 30);
        sv = (pl * t) >> 30;
        v = (sv + 64'h2000) >> 14;
        if (v > 65536) v = 65536;
        return quad[1] ? -longint'(v) : longint'(v);
    endfunction

    task automatic predict_quad(sprite_t s);
        longint sn, cs, w, h, ox0, oy0, ox, oy, rx, ry;
        vertex_t vx;
        sn = turn_sine(s.ang);
        cs = turn_sine(s.ang + AW'(1 << QB));
        w = longint'(s.w);
        h = longint'(s.h);
        ox0 = clampc(-fx_mul(s.pvx, w));
        oy0 = clampc(-fx_mul(s.pvy, h));
        for (int k = 0; k < 4; k++) begin
            ox = k[0] ? clampc(ox0 + w) : ox0;
            oy = k[1] ? clampc(oy0 + h) : oy0;
            rx = clampc(fx_mul(cs, ox) + fx_mul(sn, oy));
            ry = clampc(fx_mul(cs, oy) - fx_mul(sn, ox));
            vx.x = CW'(clampc(s.px + rx));
            vx.y = CW'(clampc(s.py + ry));
            vx.z = s.pz;
            vx.u = k[0] ^ s.mu;
            vx.v = k[1] ^ s.mv;
            vx.idx = 2'(k);
            vx.last = (2'(k) == CORNER_LAST);
            corners_due.push_back(vx);
        end
    endtask

    function automatic sprite_t rand_sprite();
        sprite_t s;
        logic [255:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom};
        s = raw[$bits(sprite_t)-1:0];
        case ($urandom_range(0, 3))
            0: ;
            default: begin
                s.px = $signed(32'($urandom_range(0, 2000000))) - 1000000 <<< 4;
                s.py = $signed(32'($urandom_range(0, 2000000))) - 1000000 <<< 4;
                s.pvx = $urandom_range(0, 65536);
                s.pvy = $urandom_range(0, 65536);
                s.w = 31'($urandom_range(0, 1 << 24));
                s.h = 31'($urandom_range(0, 1 << 24));
            end
        endcase
        return s;
    endfunction

    // directed rows; corner 0 position given where obvious
    function automatic row_t mk(sprite_t s, logic known, int x0, int y0);
        row_t r;
        r.s = s; r.known = known; r.x0 = x0; r.y0 = y0;
        return r;
    endfunction

    task automatic build_rows();
        sprite_t s;
        s = '0;
        rows.push_back(mk(s, 1, 0, 0));
        s.px = 32'sh0001_0000; s.py = 32'sh0002_0000; s.w = 31'h0004_0000;
        s.h = 31'h0002_0000;
        rows.push_back(mk(s, 1, 32'sh0001_0000, 32'sh0002_0000));
        s.mu = 1; rows.push_back(mk(s, 0, 0, 0));
        s.mv = 1; rows.push_back(mk(s, 0, 0, 0));
        s.pvx = 32'sh0000_8000; s.pvy = 32'sh0000_8000; s.mu = 0;
        rows.push_back(mk(s, 1, 32'sh_FFFF_0000, 32'sh0001_0000));
        for (int a = 0; a < 8; a++) begin
            s.ang = 16'(a * 16'h2000);
            rows.push_back(mk(s, 0, 0, 0));
        end
        s.ang = 16'hFFFF; rows.push_back(mk(s, 0, 0, 0));
        s = '0; s.px = 32'h7FFF_FFFF; s.py = 32'h8000_0000;
        s.w = '1; s.h = '1; s.pvx = 32'sh8000_0000; s.pvy = 32'sh7FFF_FFFF;
        s.pz = 32'h8000_0000;
        rows.push_back(mk(s, 1, 32'h7FFF_FFFF, 32'h8000_0000));
        s.ang = 16'h4000; s.pz = 32'h7FFF_FFFF; s.mu = 1; s.mv = 1;
        rows.push_back(mk(s, 0, 0, 0));
        s = '1; rows.push_back(mk(s, 0, 0, 0));
        s.pvx = -32'sh0001_0000; s.pvy = 32'sh0003_0000; s.w = 31'h10_0000;
        s.h = 31'h8_0000; s.px = 0; s.py = 0;
        rows.push_back(mk(s, 0, 0, 0));
    endtask

    task automatic send(sprite_t s);
        in_valid <= 1'b1;
        cur <= s;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_quad(s);
    endtask

    task automatic idle_burst();
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            cur <= rand_sprite();
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (corners_due.size() == 0) begin
                $error("vertex item with nothing expected");
                errors++;
            end else begin
                vertex_t e;
                e = corners_due.pop_front();
                if (vert_x !== e.x) begin
                    $error("vert_x exp %h got %h", e.x, vert_x); errors++;
                end
                if (vert_y !== e.y) begin
                    $error("vert_y exp %h got %h", e.y, vert_y); errors++;
                end
                if (vert_z !== e.z) begin
                    $error("vert_z exp %h got %h", e.z, vert_z); errors++;
                end
                if (tex_u !== e.u) begin
                    $error("tex_u exp %b got %b", e.u, tex_u); errors++;
                end
                if (tex_v !== e.v) begin
                    $error("tex_v exp %b got %b", e.v, tex_v); errors++;
                end
                if (corner_index !== e.idx) begin
                    $error("corner_index exp %0d got %0d", e.idx, corner_index);
                    errors++;
                end
                if (last_vertex !== e.last) begin
                    $error("last_vertex exp %b got %b", e.last, last_vertex);
                    errors++;
                end
            end
        end
    end

    // receiver stall bursts
    initial begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 4) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        row_t r;
        int wait_cycles;
        in_valid = 1'b0;
        cur = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        build_rows();
        foreach (rows[i]) begin
            r = rows[i];
            if (r.known) begin
                send(r.s);
                if (corners_due[corners_due.size() - 4].x !== r.x0 ||
                    corners_due[corners_due.size() - 4].y !== r.y0) begin
                    $error("predictor corner x/y exp %h %h got %h %h", r.x0, r.y0,
                           corners_due[corners_due.size() - 4].x,
                           corners_due[corners_due.size() - 4].y);
                    errors++;
                end
            end else begin
                send(r.s);
            end
            idle_burst();
        end
        for (int n = 0; n < 200; n++) begin
            if (n == 160) calm = 1;
            send(rand_sprite());
            idle_burst();
        end
        in_valid <= 1'b0;
        wait_cycles = 0;
        while (corners_due.size() != 0 && wait_cycles < 20000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (30) @(posedge clk);
        if (errors == 0 && corners_due.size() == 0)
            $display("rotated_sprite_quad_corners regression: pass");
        else
            $display("rotated_sprite_quad_corners regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/rsq_pkg.sv
rtl/core/rsq_queue.sv
rtl/core/rsq_front.sv
rtl/core/rsq_back.sv
rtl/core/rotated_sprite_quad_corners.sv
dv/tb_rotated_sprite_quad_corners.sv
